>>> rtl/core/dhs_pkg.sv
// Shared types and constants for the double hashing set engine.
package dhs_pkg;

	localparam int KEY_W       = 31;
	localparam int OCC_W       = 10;
	localparam int CNT_W       = 11;
	localparam int OP_W        = 2;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;
	localparam int HASH_BITS   = 32;
	localparam int HASH_RADIX  = 4;
	localparam int HASH_STEPS  = HASH_BITS / HASH_RADIX;
	localparam int HASH_CNT_W  = $clog2(HASH_STEPS);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
	localparam logic [ST_W-1:0] ST_USED  = 2'd1;
	localparam logic [ST_W-1:0] ST_GONE  = 2'd2;

	typedef struct packed {
		logic take_item;
		logic hash_load;
		logic rd_en;
		logic adv;
		logic mark_tomb;
		logic fill;
		logic erase;
		logic set_ok;
		logic clr_step;
		logic load_out;
	} dhs_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            hash_done;
		logic            clr_last;
		logic [ST_W-1:0] slot_st;
		logic            key_hit;
		logic            last_probe;
		logic            have_tomb;
		logic            out_busy;
	} dhs_stat_t;

endpackage

>>> rtl/core/dhs_mod.sv
// Radix-16 remainder unit giving key mod size and key mod (size - 1).
module dhs_mod import dhs_pkg::*; #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_W-1:0]              key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] rem_a,
	output logic [$clog2(TABLE_SIZE)-1:0] rem_b
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [IDX_W:0] MOD_A = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W:0] MOD_B = (IDX_W+1)'(TABLE_SIZE - 1);

	logic [HASH_BITS-1:0]  sh_q;
	logic [IDX_W-1:0]      ra_q;
	logic [IDX_W-1:0]      rb_q;
	logic [HASH_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [IDX_W-1:0]      ra_d;
	logic [IDX_W-1:0]      rb_d;
	logic [IDX_W:0]        wa;
	logic [IDX_W:0]        wb;

	always_comb begin
		ra_d = ra_q;
		rb_d = rb_q;
		wa = '0;
		wb = '0;
		for (int i = 0; i < HASH_RADIX; i++) begin
			wa = {ra_d, sh_q[HASH_BITS-1-i]};
			wb = {rb_d, sh_q[HASH_BITS-1-i]};
			if (wa >= MOD_A) begin
				wa = wa - MOD_A;
			end
			if (wb >= MOD_B) begin
				wb = wb - MOD_B;
			end
			ra_d = wa[IDX_W-1:0];
			rb_d = wb[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == HASH_CNT_W'(HASH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= {{(HASH_BITS-KEY_W){1'b0}}, key};
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << HASH_RADIX;
			ra_q <= ra_d;
			rb_q <= rb_d;
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

>>> rtl/core/dhs_datapath.sv
// Datapath: item registers, slot memory, probe arithmetic, live count and output register.
module dhs_datapath import dhs_pkg::*; #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dhs_cmd_t               cmd,
	output dhs_stat_t              stat,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int WORD_W = ST_W + KEY_W;

	logic [WORD_W-1:0] slot_mem [TABLE_SIZE];

	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  tomb_q;
	logic              have_tomb_q;
	logic              ok_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  clr_q;
	logic [WORD_W-1:0] rd_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              hash_done;
	logic [IDX_W-1:0]  rem_a;
	logic [IDX_W-1:0]  rem_b;
	logic [IDX_W:0]    sum;
	logic [IDX_W-1:0]  idx_next;
	logic              we;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	dhs_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.take_item),
		.key   (s_tdata[OP_W +: KEY_W]),
		.done  (hash_done),
		.rem_a (rem_a),
		.rem_b (rem_b)
	);

	always_comb begin
		sum = {1'b0, idx_q} + {1'b0, step_q};
		if (sum >= (IDX_W+1)'(TABLE_SIZE)) begin
			sum = sum - (IDX_W+1)'(TABLE_SIZE);
		end
		idx_next = sum[IDX_W-1:0];
	end

	always_comb begin
		we = 1'b0;
		wr_addr = idx_q;
		wr_data = {ST_GONE, key_q};
		if (cmd.clr_step) begin
			we = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.fill) begin
			we = 1'b1;
			wr_addr = have_tomb_q ? tomb_q : idx_q;
			wr_data = {ST_USED, key_q};
		end else if (cmd.erase) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= slot_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q <= s_tdata[OP_W-1:0];
			key_q <= s_tdata[OP_W +: KEY_W];
		end
		if (cmd.hash_load) begin
			idx_q <= rem_a;
			step_q <= rem_b + 1'b1;
			n_q <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_next;
			n_q <= n_q + 1'b1;
		end
		if (cmd.mark_tomb) begin
			tomb_q <= idx_q;
		end
		if (cmd.load_out) begin
			out_data_q <= {{(OUT_TDATA_W-OCC_W-1){1'b0}}, cnt_q[OCC_W-1:0], ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_tomb_q <= 1'b0;
			ok_q <= 1'b0;
			cnt_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_item) begin
				have_tomb_q <= 1'b0;
				ok_q <= 1'b0;
			end else begin
				if (cmd.mark_tomb) begin
					have_tomb_q <= 1'b1;
				end
				if (cmd.set_ok) begin
					ok_q <= 1'b1;
				end
			end
			if (cmd.fill) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.erase) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.op = op_q;
		stat.hash_done = hash_done;
		stat.clr_last = (clr_q == IDX_W'(TABLE_SIZE - 1));
		stat.slot_st = rd_q[KEY_W +: ST_W];
		stat.key_hit = (rd_q[KEY_W-1:0] == key_q);
		stat.last_probe = (n_q == IDX_W'(TABLE_SIZE - 1));
		stat.have_tomb = have_tomb_q;
		stat.out_busy = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> rtl/core/dhs_ctrl.sv
// Controller state machine that sequences clearing, hashing and probing.
module dhs_ctrl import dhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output dhs_cmd_t  cmd,
	input  dhs_stat_t stat
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_EVAL,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   is_used;

	assign is_used = (stat.slot_st == ST_USED);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take_item = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (stat.hash_done) begin
					cmd.hash_load = 1'b1;
					state_d = (stat.op == OP_NOP) ? S_FINISH : S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.op == OP_INSERT) begin
					if (stat.slot_st == ST_EMPTY) begin
						cmd.fill = 1'b1;
						cmd.set_ok = 1'b1;
						state_d = S_FINISH;
					end else if (is_used && stat.key_hit) begin
						state_d = S_FINISH;
					end else begin
						cmd.mark_tomb = !is_used && !stat.have_tomb;
						if (stat.last_probe) begin
							cmd.fill = stat.have_tomb || !is_used;
							cmd.set_ok = stat.have_tomb || !is_used;
							state_d = S_FINISH;
						end else begin
							cmd.adv = 1'b1;
							state_d = S_READ;
						end
					end
				end else begin
					if (stat.slot_st == ST_EMPTY) begin
						state_d = S_FINISH;
					end else if (is_used && stat.key_hit) begin
						cmd.set_ok = 1'b1;
						cmd.erase = (stat.op == OP_ERASE);
						state_d = S_FINISH;
					end else if (stat.last_probe) begin
						state_d = S_FINISH;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_READ;
					end
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

>>> rtl/core/double_hash_set_engine_top.sv
// Top level of the double hashing set engine.
// After reset the block sweeps the slot memory to empty, one slot per cycle, and takes no
// beat until that pass ends. An operation then passes through an accept state, the remainder
// unit that forms the first slot and the probe step (eight steps of four key bits each, then
// a load of the remainders), one read of the slot memory and one decision per probe, and a
// hand-over of the result to the output register; the hand-over waits while that register
// still holds a result not yet taken. The unused opcode skips the probes. A new beat is
// accepted while a finished result still waits on the output side.
module double_hash_set_engine_top import dhs_pkg::*; #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode[1:0], key[32:2], zero padding
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // success[0], occupancy[10:1], zero padding
);

	dhs_cmd_t  cmd;
	dhs_stat_t stat;

	dhs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	dhs_datapath #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
